FILE: sv/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_VERSION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 2'd1;

    localparam logic [7:0]  FRAME_VERSION_RST   = 8'd1;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd512;

    // Status codes, first failing check wins
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_PREAMBLE = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_MODE     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;
    localparam logic [2:0] ST_SIZE     = 3'd6;
    localparam logic [2:0] ST_CRC      = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [2:0]  status_code;
        logic [1:0]  mode_code;
        logic [15:0] hdr_length;
    } out_item_t;

    // Current register settings seen by the parser
    typedef struct packed {
        logic [7:0]  frame_version;
        logic [15:0] max_payload_len;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/cfd_in_reg.sv
`default_nettype none

module cfd_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire cfd_pkg::in_item_t item,
    input  wire logic            advance,
    output logic                 held_valid,
    output cfd_pkg::in_item_t    held_item
);
    import cfd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    in_item_t  item_reg;
    logic      take;

    // Slot is free when empty or when its byte moves on this cycle
    assign item_ready = !valid_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

FILE: sv/cfd_parser.sv
`default_nettype none

module cfd_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfd_pkg::cfg_t     cfg,
    input  wire cfd_pkg::in_item_t held_item,
    input  wire logic              advance,
    output logic                   res_valid,
    output cfd_pkg::out_item_t     res
);
    import cfd_pkg::*;

    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    logic [16:0] pos_reg;
    logic [16:0] pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [7:0]  mode_reg;
    logic [7:0]  mode_next;
    logic [15:0] trailer_reg;
    logic [15:0] trailer_next;
    logic        pre_bad_reg;
    logic        pre_bad_next;
    logic        ver_bad_reg;
    logic        ver_bad_next;
    logic        mode_bad_reg;
    logic        mode_bad_next;

    logic [7:0]  b;
    logic [16:0] body_end;
    logic        in_body;
    logic [17:0] size;
    logic [2:0]  status;
    logic [1:0]  mode_of;
    logic        header_ok;
    logic [15:0] crc_upd;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign b = held_item.data_byte;

    // Header field capture and sticky check flags
    always_comb
    begin
        pre_bad_next  = pre_bad_reg;
        ver_bad_next  = ver_bad_reg;
        mode_bad_next = mode_bad_reg;
        mode_next     = mode_reg;
        len_next      = len_reg;
        unique case (pos_reg)
            17'd0:
            begin
                if (b != 8'h55) pre_bad_next = 1'b1;
            end
            17'd1:
            begin
                if (b != 8'hAA) pre_bad_next = 1'b1;
            end
            17'd2:
            begin
                if (b != cfg.frame_version) ver_bad_next = 1'b1;
            end
            17'd3:
            begin
                mode_next = b;
                if (b != 8'h01 && b != 8'h02) mode_bad_next = 1'b1;
            end
            17'd4:   len_next = {b, 8'h00};
            17'd5:   len_next = {len_reg[15:8], b};
            default: ;
        endcase
    end

    // CRC covers version through last payload byte
    assign body_end     = 17'd6 + {1'b0, len_next};
    assign in_body      = (pos_reg >= 17'd6) && (pos_reg < body_end);
    assign crc_upd      = crc_byte(crc_reg, b);
    assign trailer_next = {trailer_reg[7:0], b};
    assign size         = {1'b0, pos_reg} + 18'd1;
    assign mode_of      = (mode_next == 8'h01 || mode_next == 8'h02) ? mode_next[1:0] : 2'd0;
    assign header_ok    = !pre_bad_next && !ver_bad_next && !mode_bad_next &&
                          (len_next <= cfg.max_payload_len);

    always_comb
    begin
        crc_next = crc_reg;
        if (pos_reg >= 17'd2 && pos_reg < body_end)
        begin
            crc_next = crc_upd;
        end
    end

    // End-of-frame status, first failing check
    always_comb
    begin
        if (size < 18'd8)                                    status = ST_SHORT;
        else if (pre_bad_next)                               status = ST_PREAMBLE;
        else if (ver_bad_next)                               status = ST_VERSION;
        else if (mode_bad_next)                              status = ST_MODE;
        else if (len_next > cfg.max_payload_len)             status = ST_TOO_LONG;
        else if (size != 18'd8 + {2'b00, len_next})          status = ST_SIZE;
        else if (crc_next != trailer_next)                   status = ST_CRC;
        else                                                 status = ST_OK;
    end

    // Result of the held byte
    always_comb
    begin
        res = '0;
        if (held_item.frame_end)
        begin
            res_valid       = 1'b1;
            res.is_status   = 1'b1;
            res.status_code = status;
            res.mode_code   = (status == ST_SHORT) ? 2'd0 : mode_of;
            res.hdr_length  = (status == ST_SHORT) ? 16'd0 : len_next;
        end
        else
        begin
            res_valid        = header_ok && in_body;
            res.payload_byte = b;
            res.mode_code    = mode_of;
            res.hdr_length   = len_next;
        end
    end

    // Position counter saturates on overlong frames
    assign pos_next = (pos_reg < POS_MAX) ? pos_reg + 17'd1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= 16'hFFFF;
            len_reg      <= '0;
            mode_reg     <= '0;
            trailer_reg  <= '0;
            pre_bad_reg  <= 1'b0;
            ver_bad_reg  <= 1'b0;
            mode_bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (held_item.frame_end)
            begin
                pos_reg      <= '0;
                crc_reg      <= 16'hFFFF;
                len_reg      <= '0;
                mode_reg     <= '0;
                trailer_reg  <= '0;
                pre_bad_reg  <= 1'b0;
                ver_bad_reg  <= 1'b0;
                mode_bad_reg <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                len_reg      <= len_next;
                mode_reg     <= mode_next;
                trailer_reg  <= trailer_next;
                pre_bad_reg  <= pre_bad_next;
                ver_bad_reg  <= ver_bad_next;
                mode_bad_reg <= mode_bad_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfd_out_reg.sv
`default_nettype none

module cfd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire cfd_pkg::out_item_t res,
    output logic                    free,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output cfd_pkg::out_item_t      result
);
    import cfd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // Empty, or its result leaves on this edge
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire

FILE: sv/crc_checked_frame_decoder.sv
// Frame decoder with CRC-16/CCITT-FALSE check.
// Bytes come in on the item channel (valid/ready), frame_end set on the last
// byte of each frame. Once preamble, version, mode and length checks pass,
// payload bytes go out on the result channel as they arrive (is_status = 0).
// The last byte yields one status transfer (is_status = 1) naming the first
// failing check; the decoder then starts over for the next frame.
// Throughput: one byte per cycle while the receiver takes results. Each item
// is held in the input register and passes through the parser into the
// result register; the byte-wide CRC update is combinational.
// Bytes that yield no result pass through without waiting on the receiver.
// A stalled receiver holds the result register; one more byte is taken into
// the input register, after which item_ready drops until the result leaves.
// Reset clears the frame state and loads frame_version = 1 and
// max_payload_len = 512. Write registers through cfg_we/cfg_index/cfg_wdata
// only while no frame is in flight; unknown indexes are ignored.
`default_nettype none

module crc_checked_frame_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire cfd_pkg::in_item_t                 item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output cfd_pkg::out_item_t                     result,
    input  wire logic                              cfg_we,
    input  wire logic [cfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cfd_pkg::*;

    cfg_t      cfg_reg;
    logic      held_valid;
    in_item_t  held_item;
    logic      res_valid;
    out_item_t res;
    logic      out_free;
    logic      advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_version   <= FRAME_VERSION_RST;
            cfg_reg.max_payload_len <= MAX_PAYLOAD_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_VERSION:   cfg_reg.frame_version   <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD_LEN: cfg_reg.max_payload_len <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Byte moves through the parser when its result has somewhere to go
    assign advance = held_valid && (!res_valid || out_free);

    cfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    cfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .held_item (held_item),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    cfd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && res_valid),
        .res          (res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
